>>> rtl/smtp_reply_line_parser_assert.svh
// Assertion macros for the SMTP reply line parser.
// Used by the RTL files that carry concurrent checks; expects a clk and rst_n in scope.
`ifndef SMTP_REPLY_LINE_PARSER_ASSERT_SVH
`define SMTP_REPLY_LINE_PARSER_ASSERT_SVH

// Check that is held off while reset is asserted
`define SRLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also runs during reset
`define SRLP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/srlp_pkg.sv
// Shared types and constants for the SMTP reply line parser.
// No dependencies; imported by srlp_parser and smtp_reply_line_parser.
package srlp_pkg;

  // Characters
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DASH  = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  // Reply codes of interest
  localparam logic [9:0] CODE_MULTI_DEFAULT = 10'd250;
  localparam logic [9:0] CODE_AUTH          = 10'd334;
  localparam logic [9:0] CODE_READY         = 10'd220;
  localparam logic [9:0] CODE_CLOSING       = 10'd221;
  localparam logic [9:0] CODE_UNAVAIL       = 10'd421;

  // Line offsets
  localparam logic [2:0] POS_FOURTH  = 3'd3;
  localparam logic [2:0] TEXT_OFFSET = 3'd4;

  // Byte roles
  localparam logic [1:0] ROLE_PLAIN    = 2'd0;
  localparam logic [1:0] ROLE_PARAM    = 2'd1;
  localparam logic [1:0] ROLE_CONT     = 2'd2;
  localparam logic [1:0] ROLE_LINE_END = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_SHORT_LINE  = 3'd1;
  localparam logic [2:0] ST_NO_CODE     = 3'd2;
  localparam logic [2:0] ST_BAD_FOURTH  = 3'd3;
  localparam logic [2:0] ST_NO_MULTI    = 3'd4;
  localparam logic [2:0] ST_SHORT_CONT  = 3'd5;
  localparam logic [2:0] ST_MISMATCH    = 3'd6;

  // Parameter tagging modes
  localparam logic [1:0] PMODE_NONE  = 2'd0;
  localparam logic [1:0] PMODE_REST  = 2'd1;
  localparam logic [1:0] PMODE_SPACE = 2'd2;

  // One result per input byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] role;
    logic [9:0] reply_code;
    logic [2:0] status;
    logic       reply_done;
    logic       param_valid;
    logic [7:0] continuation_lines;
  } srlp_result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [3:0] digit_val(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    return d[3:0];
  endfunction

endpackage

>>> rtl/srlp_parser.sv
// Parser state and per-byte decode for the SMTP reply line parser.
// Depends on srlp_pkg and smtp_reply_line_parser_assert.svh.
`include "smtp_reply_line_parser_assert.svh"

module srlp_parser
  import srlp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [7:0]   byte_in,
  input  logic [9:0]   multiline_code,
  output srlp_result_t result
);

  logic [2:0]      pos_r, pos_nxt;
  logic [2:0][7:0] digits_r, digits_nxt;
  logic [9:0]      code_r, code_nxt;
  logic            in_cont_r, in_cont_nxt;
  logic [1:0]      pmode_r, pmode_nxt;
  logic            space_r, space_nxt;
  logic            skip_r, skip_nxt;
  logic [7:0]      cont_r, cont_nxt;
  logic            more_r, more_nxt;
  logic            mism_r, mism_nxt;

  logic            fresh;
  logic [9:0]      code_calc;
  logic            digits_ok;

  // Reply code from the three stored digits
  assign digits_ok = is_digit(digits_r[0]) && is_digit(digits_r[1]) && is_digit(digits_r[2]);
  assign code_calc = 10'(digit_val(digits_r[0])) * 10'd100
                   + 10'(digit_val(digits_r[1])) * 10'd10
                   + 10'(digit_val(digits_r[2]));

  // Per-byte decode and next state
  always_comb begin
    pos_nxt     = pos_r;
    digits_nxt  = digits_r;
    code_nxt    = code_r;
    in_cont_nxt = in_cont_r;
    pmode_nxt   = pmode_r;
    space_nxt   = space_r;
    skip_nxt    = skip_r;
    cont_nxt    = cont_r;
    more_nxt    = more_r;
    mism_nxt    = mism_r;
    fresh       = 1'b0;

    result             = '0;
    result.out_byte    = byte_in;
    result.role        = ROLE_PLAIN;
    result.status      = ST_OK;

    if (byte_in == CH_CR) begin
      // dropped, state untouched
    end else if (skip_r) begin
      if (byte_in == CH_LF) begin
        result.role = ROLE_LINE_END;
        fresh       = 1'b1;
      end
    end else if (byte_in == CH_LF) begin
      result.role = ROLE_LINE_END;
      if (pos_r < TEXT_OFFSET) begin
        result.status     = in_cont_r ? ST_SHORT_CONT : ST_SHORT_LINE;
        result.reply_done = 1'b1;
        fresh             = 1'b1;
      end else begin
        if (!in_cont_r) begin
          result.param_valid = (pmode_r == PMODE_REST) || ((pmode_r == PMODE_SPACE) && space_r);
        end
        if (more_r) begin
          in_cont_nxt = 1'b1;
          pos_nxt     = '0;
          mism_nxt    = 1'b0;
          more_nxt    = 1'b0;
        end else begin
          result.reply_done = 1'b1;
          fresh             = 1'b1;
        end
      end
    end else if (pos_r < POS_FOURTH) begin
      // leading code bytes: store on first line, compare on continuation
      if (in_cont_r) begin
        if (byte_in != digits_r[pos_r[1:0]]) begin
          mism_nxt = 1'b1;
        end
      end else begin
        digits_nxt[pos_r[1:0]] = byte_in;
      end
      pos_nxt = pos_r + 3'd1;
    end else if (pos_r == POS_FOURTH) begin
      // fourth byte: judge code and separator
      if (!in_cont_r) begin
        if (!digits_ok) begin
          result.status = ST_NO_CODE;
        end else begin
          code_nxt = code_calc;
          if (byte_in == CH_SPACE) begin
            more_nxt = 1'b0;
          end else if (byte_in == CH_DASH) begin
            if (code_calc == multiline_code) begin
              more_nxt = 1'b1;
            end else begin
              result.status = ST_NO_MULTI;
            end
          end else begin
            result.status = ST_BAD_FOURTH;
          end
          if (code_calc == CODE_AUTH) begin
            pmode_nxt = PMODE_REST;
          end else if (code_calc == CODE_READY || code_calc == CODE_CLOSING ||
                       code_calc == CODE_UNAVAIL) begin
            pmode_nxt = PMODE_SPACE;
          end else begin
            pmode_nxt = PMODE_NONE;
          end
        end
      end else begin
        if (mism_r) begin
          result.status = ST_MISMATCH;
        end else begin
          if (cont_r != 8'hFF) begin
            cont_nxt = cont_r + 8'd1;
          end
          more_nxt = (byte_in == CH_DASH);
        end
      end
      if (result.status != ST_OK) begin
        result.reply_done = 1'b1;
        skip_nxt          = 1'b1;
      end
      pos_nxt = TEXT_OFFSET;
    end else begin
      // text bytes
      if (in_cont_r) begin
        result.role = ROLE_CONT;
      end else if (pmode_r == PMODE_REST) begin
        result.role = ROLE_PARAM;
      end else if ((pmode_r == PMODE_SPACE) && !space_r) begin
        if (byte_in == CH_SPACE) begin
          space_nxt = 1'b1;
        end else begin
          result.role = ROLE_PARAM;
        end
      end
    end

    // Fields reflect this byte's update, before any restart
    result.reply_code         = code_nxt;
    result.continuation_lines = cont_nxt;

    if (fresh) begin
      pos_nxt     = '0;
      digits_nxt  = '0;
      code_nxt    = '0;
      in_cont_nxt = 1'b0;
      pmode_nxt   = PMODE_NONE;
      space_nxt   = 1'b0;
      skip_nxt    = 1'b0;
      cont_nxt    = '0;
      more_nxt    = 1'b0;
      mism_nxt    = 1'b0;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      digits_r  <= '0;
      code_r    <= '0;
      in_cont_r <= 1'b0;
      pmode_r   <= PMODE_NONE;
      space_r   <= 1'b0;
      skip_r    <= 1'b0;
      cont_r    <= '0;
      more_r    <= 1'b0;
      mism_r    <= 1'b0;
    end else if (step) begin
      pos_r     <= pos_nxt;
      digits_r  <= digits_nxt;
      code_r    <= code_nxt;
      in_cont_r <= in_cont_nxt;
      pmode_r   <= pmode_nxt;
      space_r   <= space_nxt;
      skip_r    <= skip_nxt;
      cont_r    <= cont_nxt;
      more_r    <= more_nxt;
      mism_r    <= mism_nxt;
    end
  end

  `SRLP_ASSERT(a_pos_range, pos_r <= TEXT_OFFSET, "line position out of range")
  `SRLP_ASSERT(a_skip_after_fourth, skip_r |-> (pos_r == TEXT_OFFSET), "skip set before fourth byte")
  `SRLP_ASSERT(a_cont_needs_line, (cont_r != 8'd0) |-> in_cont_r, "continuation count outside continuation")

endmodule

>>> rtl/smtp_reply_line_parser.sv
// Top level of the SMTP reply line parser: input register, config register, result register.
// Depends on srlp_pkg, srlp_parser and smtp_reply_line_parser_assert.svh.
//
// Usage:
//   Input channel in_valid/in_ready/in_byte carries the reply stream, one byte per request.
//   Result channel out_valid/out_ready carries one result per byte: the byte itself, its
//   role, the parsed reply code, an error status, reply_done, param_valid and the running
//   count of continuation lines.
//   Config channel cfg_valid/cfg_ready/cfg_multiline_code sets the one reply code that may
//   span several lines; cfg_ready is always high. Write it only while the block is idle.
// Timing:
//   An accepted byte is held in the input register, then the decode writes its result into the
//   result register; a stall on out_ready can come between the two. Throughput is one byte per cycle
//   while out_ready allows, set by the single decode stage that updates the parser state.
// Reset:
//   rst_n (synchronous, active low) empties both registers, clears the parser state and
//   sets the multiline code back to 250.
// Stall:
//   When out_ready is low with a result pending, the held byte stays in the input
//   register and in_ready drops; no request is lost or repeated.
`include "smtp_reply_line_parser_assert.svh"

module smtp_reply_line_parser
  import srlp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_role,
  output logic [9:0] out_reply_code,
  output logic [2:0] out_status,
  output logic       out_reply_done,
  output logic       out_param_valid,
  output logic [7:0] out_continuation_lines,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [9:0] cfg_multiline_code
);

  logic         s1_valid_r;
  logic [7:0]   s1_byte_r;
  logic         advance;
  logic [9:0]   multi_r;
  logic         out_valid_r;
  srlp_result_t out_r;
  srlp_result_t result;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      multi_r <= CODE_MULTI_DEFAULT;
    end else if (cfg_valid) begin
      multi_r <= cfg_multiline_code;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
    end
  end

  srlp_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .byte_in        (s1_byte_r),
    .multiline_code (multi_r),
    .result         (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_byte               = out_r.out_byte;
  assign out_role               = out_r.role;
  assign out_reply_code         = out_r.reply_code;
  assign out_status             = out_r.status;
  assign out_reply_done         = out_r.reply_done;
  assign out_param_valid        = out_r.param_valid;
  assign out_continuation_lines = out_r.continuation_lines;

  `SRLP_ASSERT(a_err_ends_reply, (out_valid_r && (out_r.status != ST_OK)) |-> out_r.reply_done, "error without reply_done")
  `SRLP_ASSERT(a_pv_on_line_end, (out_valid_r && out_r.param_valid) |-> (out_r.role == ROLE_LINE_END), "param_valid off line end")
  `SRLP_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> (!out_valid_r && !s1_valid_r), "registers not empty after reset")

endmodule
